// File: rtl/mandelbrot_escape_counter_unit_assert.svh
// assertion macros for the escape counter unit
// no dependencies; included by the rtl of the escape counter unit, which checks its own logic
`ifndef MANDELBROT_ESCAPE_COUNTER_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_COUNTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MEC_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mec: same-cycle check failed");
// next-cycle implication
`define MEC_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mec: next-cycle check failed");
`else
`define MEC_ASSERT_IMP(label, clk, rst_n, pre, post)
`define MEC_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

// File: rtl/mec_pkg.sv
// shared constants, widths and types of the escape counter unit
// no dependencies
package mec_pkg;

  // fixed point format and image size
  localparam int FRAC_BITS = 28;
  localparam int MAX_DIM   = 4096;   // power of two, index wraps by masking

  // field widths
  localparam int IDX_W  = 12;
  localparam int ORG_W  = 32;
  localparam int STEP_W = 31;
  localparam int LIM_W  = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // datapath widths
  localparam int MUL_W   = STEP_W;                 // shared multiplier operand width
  localparam int PROD_W  = 2 * MUL_W;
  localparam int PIDX_W  = IDX_W + STEP_W;         // index times step
  localparam int XW      = PIDX_W + 3;             // c and z, signed
  localparam int MAG_W   = FRAC_BITS + 2;          // magnitude up to 2.0
  localparam int SQ_W    = 2 * FRAC_BITS + 3;      // square of a magnitude up to 2.0
  localparam int DIFF_W  = SQ_W + 1;
  localparam int Q_W     = SQ_W - FRAC_BITS + 1;   // scaled 2xy

  localparam logic [IDX_W-1:0] DIM_MASK = IDX_W'(MAX_DIM - 1);
  localparam logic [XW-1:0]    TWO_FULL = XW'(2) << FRAC_BITS;
  localparam logic [MAG_W-1:0] TWO_MAG  = MAG_W'(2) << FRAC_BITS;
  localparam logic [SQ_W:0]    FOUR_SQ  = (SQ_W + 1)'(1) << (2 * FRAC_BITS + 2);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd4;

  // register reset values: window of -2 to 2 over 100 pixels, 1000 iterations
  localparam logic [ORG_W-1:0]  RST_REAL_ORIGIN     = 32'hE000_0000;
  localparam logic [ORG_W-1:0]  RST_IMAG_ORIGIN     = 32'hE000_0000;
  localparam logic [STEP_W-1:0] RST_REAL_STEP       = 31'd10737418;
  localparam logic [STEP_W-1:0] RST_IMAG_STEP       = 31'd10737418;
  localparam logic [LIM_W-1:0]  RST_ITERATION_LIMIT = 16'd1000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRE,    // col * real_step
    ST_CIM,    // row * imag_step, real part of c
    ST_CADD,   // imaginary part of c
    ST_TEST,   // limit check, magnitudes
    ST_SQX,    // range check, x * x
    ST_SQY,    // y * y
    ST_XY,     // x * y, escape test
    ST_UPD,    // z update
    ST_FIN     // hand result to the output register
  } mec_state_t;

endpackage

// File: rtl/mandelbrot_escape_counter_unit.sv
// mandelbrot escape-time counter: one shared multiplier under a small sequencer
// depends on mec_pkg and mandelbrot_escape_counter_unit_assert.svh
//
// usage
//   input channel in_valid / in_stall carries one word: pixel column and row.
//   the word is taken when in_valid is high and in_stall is low. the unit maps
//   it to c = origin + index * step (signed q4.28), iterates z = z*z + c from
//   z = 0 while |z|^2 <= 4 and the count is below iteration_limit, and sends
//   one result word on out_valid / out_stall: the count, or 0 if the limit
//   was reached.
//   config writes (cfg_valid and cfg_ready high) go to registers 0..4: real
//   origin, imag origin, real step, imag step, iteration limit. other indexes
//   are dropped. write only while no pixel is in flight.
// timing
//   one 31x31 multiplier is shared by every product, so each full iteration
//   runs through five steps (limit check, x*x, y*y, x*y, update). in_stall
//   drops in the same cycle that the result word is loaded into the output register.
// reset and stall
//   rst_n (synchronous) returns the registers to their default window and
//   drops any pixel in flight. a stalled result waits in the output register
//   while the next pixel is already taken and computed.
`include "mandelbrot_escape_counter_unit_assert.svh"

module mandelbrot_escape_counter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel words
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mec_pkg::IDX_W-1:0]      in_pixel_col,
  input  logic [mec_pkg::IDX_W-1:0]      in_pixel_row,
  // result words
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mec_pkg::LIM_W-1:0]      out_escape_count,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mec_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mec_pkg::*;

  // configuration registers
  logic [ORG_W-1:0]  real_origin_r;
  logic [ORG_W-1:0]  imag_origin_r;
  logic [STEP_W-1:0] real_step_r;
  logic [STEP_W-1:0] imag_step_r;
  logic [LIM_W-1:0]  iteration_limit_r;

  // sequencer
  mec_state_t state_r, state_nxt;

  // per-pixel datapath
  logic [IDX_W-1:0]     col_r, row_r;
  logic signed [XW-1:0] cr_r, ci_r;        // point c
  logic signed [XW-1:0] x_r, y_r;          // point z
  logic [MAG_W-1:0]     ax_r, ay_r;        // |x|, |y| while in range
  logic                 big_r;             // |x| or |y| above 2.0
  logic                 pneg_r;            // sign of x*y
  logic [SQ_W-1:0]      xx_r;
  logic signed [DIFF_W-1:0] diff_r;        // x*x - y*y
  logic                 esc_r;             // |z|^2 above 4
  logic [LIM_W-1:0]     count_r;

  // shared multiplier
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_r;

  // output register
  logic             out_valid_r;
  logic [LIM_W-1:0] out_escape_count_r;
  logic             out_load;

  // datapath terms
  logic [XW-1:0]        ax_full, ay_full;
  logic [SQ_W:0]        mag_sum;
  logic [Q_W-1:0]       q_mag;
  logic                 q_frac_nz;
  logic signed [XW-1:0] nx_ext, ny_ext;

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_escape_count = out_escape_count_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_origin_r     <= RST_REAL_ORIGIN;
      imag_origin_r     <= RST_IMAG_ORIGIN;
      real_step_r       <= RST_REAL_STEP;
      imag_step_r       <= RST_IMAG_STEP;
      iteration_limit_r <= RST_ITERATION_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REAL_ORIGIN:     real_origin_r     <= cfg_data[ORG_W-1:0];
        REG_IMAG_ORIGIN:     imag_origin_r     <= cfg_data[ORG_W-1:0];
        REG_REAL_STEP:       real_step_r       <= cfg_data[STEP_W-1:0];
        REG_IMAG_STEP:       imag_step_r       <= cfg_data[STEP_W-1:0];
        REG_ITERATION_LIMIT: iteration_limit_r <= cfg_data[LIM_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CRE;
      ST_CRE:  state_nxt = ST_CIM;
      ST_CIM:  state_nxt = ST_CADD;
      ST_CADD: state_nxt = ST_TEST;
      ST_TEST: state_nxt = (count_r == iteration_limit_r) ? ST_FIN : ST_SQX;
      ST_SQX:  state_nxt = big_r ? ST_FIN : ST_SQY;
      ST_SQY:  state_nxt = ST_XY;
      ST_XY:   state_nxt = ST_UPD;
      ST_UPD:  state_nxt = esc_r ? ST_FIN : ST_TEST;
      ST_FIN:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      ST_CRE: begin
        mul_a = MUL_W'(col_r);
        mul_b = real_step_r;
      end
      ST_CIM: begin
        mul_a = MUL_W'(row_r);
        mul_b = imag_step_r;
      end
      ST_SQX: begin
        mul_a = MUL_W'(ax_r);
        mul_b = MUL_W'(ax_r);
      end
      ST_SQY: begin
        mul_a = MUL_W'(ay_r);
        mul_b = MUL_W'(ay_r);
      end
      ST_XY: begin
        mul_a = MUL_W'(ax_r);
        mul_b = MUL_W'(ay_r);
      end
      default: ;
    endcase
  end

  // magnitudes of z, taken in the limit-check step
  assign ax_full = x_r[XW-1] ? XW'(-x_r) : XW'(x_r);
  assign ay_full = y_r[XW-1] ? XW'(-y_r) : XW'(y_r);

  // |z|^2 from x*x (registered) and y*y (fresh product)
  assign mag_sum = {1'b0, xx_r} + {1'b0, prod_r[SQ_W-1:0]};

  // floor((x*x - y*y) / 2^frac) is an arithmetic shift of the difference
  assign nx_ext = XW'(signed'(diff_r[DIFF_W-1:FRAC_BITS]));

  // floor(+-2xy / 2^frac): magnitude shifted, negated with a ceiling when negative
  assign q_mag     = prod_r[SQ_W-1:FRAC_BITS-1];
  assign q_frac_nz = |prod_r[FRAC_BITS-2:0];
  assign ny_ext    = pneg_r ? (signed'(~XW'(q_mag)) + XW'(!q_frac_nz))
                            : signed'(XW'(q_mag));

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath regs
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (out_load) begin
      out_escape_count_r <= (count_r == iteration_limit_r) ? '0 : count_r;
    end
    unique case (state_r)
      ST_IDLE: begin
        col_r   <= in_pixel_col & DIM_MASK;
        row_r   <= in_pixel_row & DIM_MASK;
        x_r     <= '0;
        y_r     <= '0;
        count_r <= '0;
      end
      ST_CIM: begin
        cr_r <= XW'(signed'(real_origin_r)) + signed'(XW'(prod_r[PIDX_W-1:0]));
      end
      ST_CADD: begin
        ci_r <= XW'(signed'(imag_origin_r)) + signed'(XW'(prod_r[PIDX_W-1:0]));
      end
      ST_TEST: begin
        ax_r   <= ax_full[MAG_W-1:0];
        ay_r   <= ay_full[MAG_W-1:0];
        big_r  <= (ax_full > TWO_FULL) || (ay_full > TWO_FULL);
        pneg_r <= x_r[XW-1] ^ y_r[XW-1];
      end
      ST_SQY: begin
        xx_r <= prod_r[SQ_W-1:0];
      end
      ST_XY: begin
        esc_r  <= (mag_sum > FOUR_SQ);
        diff_r <= signed'({1'b0, xx_r}) - signed'({1'b0, prod_r[SQ_W-1:0]});
      end
      ST_UPD: begin
        if (!esc_r) begin
          x_r     <= nx_ext + cr_r;
          y_r     <= ny_ext + ci_r;
          count_r <= count_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- checks
  `MEC_ASSERT_IMP(a_count_within_limit, clk, rst_n, state_r != ST_IDLE, count_r <= iteration_limit_r)
  `MEC_ASSERT_IMP(a_square_in_range, clk, rst_n, state_r == ST_SQY, ax_r <= TWO_MAG && ay_r <= TWO_MAG)
  `MEC_ASSERT_NXT(a_accept_starts_map, clk, rst_n, in_valid && !in_stall, state_r == ST_CRE)
  `MEC_ASSERT_NXT(a_load_frees_unit, clk, rst_n, out_load, out_valid_r && state_r == ST_IDLE)

endmodule

// File: tb/mandelbrot_escape_counter_unit_test.sv
// self-checking testbench of the mandelbrot escape-time counter unit
// depends on mec_pkg and the rtl of mandelbrot_escape_counter_unit
module mandelbrot_escape_counter_unit_test;
  import mec_pkg::*;

  // longest legal silence is one inside pixel at the top limit, plus a stall
  // burst; HANG_LIMIT is about three times that
  localparam int HANG_LIMIT = 1_000_000;
  localparam int RANDOM_PIXELS = 550;

  // escape bounds in the wide domain: |z| = 2 and |z|^2 = 4
  localparam longint TWO_Q   = longint'(2) << FRAC_BITS;
  localparam longint FOUR_QQ = longint'(4) << (2 * FRAC_BITS);

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } pixel_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [IDX_W-1:0]      in_pixel_col = '0;
  logic [IDX_W-1:0]      in_pixel_row = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LIM_W-1:0]      out_escape_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // our copy of the window and the limit, tracked from the register writes
  logic signed [ORG_W-1:0] win_re0 = RST_REAL_ORIGIN;
  logic signed [ORG_W-1:0] win_im0 = RST_IMAG_ORIGIN;
  logic [STEP_W-1:0]       win_re_step = RST_REAL_STEP;
  logic [STEP_W-1:0]       win_im_step = RST_IMAG_STEP;
  logic [LIM_W-1:0]        win_limit = RST_ITERATION_LIMIT;

  pixel_t           pixel_q[$];   // pixels waiting for the driver
  logic [LIM_W-1:0] count_q[$];   // predicted escape counts, oldest first

  int errors = 0;
  int in_gap = 0;
  int out_hold = 0;
  int quiet_cycles = 0;
  bit in_idle_on = 1'b0;
  bit out_idle_on = 1'b0;

  mandelbrot_escape_counter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_col     (in_pixel_col),
    .in_pixel_row     (in_pixel_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_escape_count (out_escape_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // escape-time count of one pixel under the current window
  function automatic logic [LIM_W-1:0] escape_time(logic [IDX_W-1:0] col,
                                                   logic [IDX_W-1:0] row);
    longint c_re, c_im, zr, zi, zr2, zi2, next_re;
    int unsigned n;
    bit escaped;
    // c is exact: origin plus index times step, no wrap, no saturation
    c_re = longint'(win_re0) + longint'(col) * longint'(win_re_step);
    c_im = longint'(win_im0) + longint'(row) * longint'(win_im_step);
    zr = 0;
    zi = 0;
    n = 0;
    escaped = 1'b0;
    while (n < win_limit && !escaped) begin
      // a coordinate beyond 2.0 escapes before any square is formed
      if (zr > TWO_Q || zr < -TWO_Q || zi > TWO_Q || zi < -TWO_Q) begin
        escaped = 1'b1;
      end else begin
        zr2 = zr * zr;
        zi2 = zi * zi;
        if (zr2 + zi2 > FOUR_QQ) begin
          escaped = 1'b1;
        end else begin
          // arithmetic shifts floor toward minus infinity
          next_re = ((zr2 - zi2) >>> FRAC_BITS) + c_re;
          zi = ((2 * zr * zi) >>> FRAC_BITS) + c_im;
          zr = next_re;
          n++;
        end
      end
    end
    // reaching the limit reads as inside the set
    return (n == win_limit) ? '0 : LIM_W'(n);
  endfunction

  // register write as the unit stores it; unknown indexes leave all alone
  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_REAL_ORIGIN:     win_re0 = d;
      REG_IMAG_ORIGIN:     win_im0 = d;
      REG_REAL_STEP:       win_re_step = d[STEP_W-1:0];
      REG_IMAG_STEP:       win_im_step = d[STEP_W-1:0];
      REG_ITERATION_LIMIT: win_limit = d[LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // one register write on the config channel, tracked once it is taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pixel(input int col, input int row);
    pixel_q.push_back('{col: IDX_W'(col), row: IDX_W'(row)});
  endtask

  // every pixel sent and every result word back: the unit is idle
  // checked mid-cycle so the driver's updates at the edge are settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || count_q.size() != 0);
  endtask

  // signed value within about +-2.5 in q4.28, or anything now and then
  function automatic logic [ORG_W-1:0] pick_origin();
    if ($urandom_range(0, 3) == 0)
      return $urandom();
    return ORG_W'(int'($urandom_range(0, 1342177280)) - 671088640);
  endfunction

  // step word, upper bit random so the 31-bit masking is exercised
  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return {$urandom_range(0, 1) == 1, 31'd0};
      1: return $urandom();
      default: return {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 32'h0100_0000))};
    endcase
  endfunction

  // limits stay small most of the time: an inside pixel iterates all the way to the limit
  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    logic [LIM_W-1:0] lim;
    case ($urandom_range(0, 7))
      0: lim = LIM_W'(1);
      1: lim = LIM_W'($urandom_range(100, 400));
      default: lim = LIM_W'($urandom_range(2, 64));
    endcase
    return {16'($urandom()), lim};
  endfunction

  // stimulus: directed windows first, then random windows and pixels
  initial begin
    int sent;
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset window, -2..2 over 100 pixels, limit 1000
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    queue_pixel(0, 0);          // corner -2-2i, escapes at once
    queue_pixel(50, 50);        // near the origin, runs to the limit
    queue_pixel(25, 50);        // near -1, period-two orbit
    queue_pixel(75, 50);        // near +1, escapes after a few steps
    queue_pixel(4095, 4095);    // far outside, the large-z shortcut
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(50, 0);
    queue_pixel(10, 60);
    wait_drained();

    // indexes past the last register must be dropped
    for (int k = REG_ITERATION_LIMIT + 1; k < 2 ** CFG_IDX_W; k++)
      write_reg(CFG_IDX_W'(k), $urandom());
    // zero limit: nothing iterates, every count reads as inside
    write_reg(REG_ITERATION_LIMIT, 32'hFFFF_0000);
    queue_pixel(50, 50);
    queue_pixel(4095, 4095);
    wait_drained();

    // limit of one
    write_reg(REG_ITERATION_LIMIT, 32'h0000_0001);
    queue_pixel(3095, 17);
    wait_drained();

    // extreme origins and steps, top limit; all of these escape at once
    write_reg(REG_REAL_ORIGIN, 32'h7FFF_FFFF);
    write_reg(REG_IMAG_ORIGIN, 32'h8000_0000);
    write_reg(REG_REAL_STEP, 32'hFFFF_FFFF);
    write_reg(REG_IMAG_STEP, 32'hFFFF_FFFF);
    write_reg(REG_ITERATION_LIMIT, 32'h0000_FFFF);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(1, 4095);
    wait_drained();

    // real axis in quarter steps from -2: -2 sits on |z| = 2 for good,
    // 0.25 is the cusp, 2.0 meets |z|^2 = 4 exactly and escapes next
    write_reg(REG_REAL_ORIGIN, 32'hE000_0000);
    write_reg(REG_IMAG_ORIGIN, 32'h0000_0000);
    write_reg(REG_REAL_STEP, 32'h0400_0000);
    write_reg(REG_IMAG_STEP, 32'h0000_0000);
    write_reg(REG_ITERATION_LIMIT, 32'd300);
    queue_pixel(0, 123);
    queue_pixel(9, 456);
    queue_pixel(16, 7);
    queue_pixel(17, 4000);
    queue_pixel(8, 0);
    wait_drained();

    // one pixel at c = 0 under the top limit: the longest single result
    write_reg(REG_REAL_ORIGIN, 32'h0000_0000);
    write_reg(REG_REAL_STEP, 32'h0000_0000);
    write_reg(REG_ITERATION_LIMIT, 32'h0000_FFFF);
    queue_pixel(2048, 2048);
    wait_drained();

    // random windows; the last one runs with no idling on either side
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      n = $urandom_range(15, 45);
      if (RANDOM_PIXELS - sent <= 60) begin
        n = RANDOM_PIXELS - sent;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end else begin
        in_idle_on  = $urandom_range(0, 2) != 0;
        out_idle_on = $urandom_range(0, 2) != 0;
      end
      write_reg(REG_REAL_ORIGIN, pick_origin());
      write_reg(REG_IMAG_ORIGIN, pick_origin());
      write_reg(REG_REAL_STEP, pick_step());
      write_reg(REG_IMAG_STEP, pick_step());
      write_reg(REG_ITERATION_LIMIT, pick_limit());
      for (int i = 0; i < n; i++) begin
        // mostly inside a small tile so the window stays near the set
        if ($urandom_range(0, 4) == 0)
          queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        else
          queue_pixel($urandom_range(0, 127), $urandom_range(0, 127));
      end
      sent += n;
      wait_drained();
    end

    // let any trailing activity settle before the verdict
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // pixel driver: a held word stays put while stalled; bursts of idle
  // cycles between words when idling is on for the current window
  always @(posedge clk) begin : pixel_driver
    pixel_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      // word taken at this edge: predict its count under the current window
      if (in_valid && !in_stall)
        count_q.push_back(escape_time(in_pixel_col, in_pixel_row));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (in_idle_on && $urandom_range(0, 3) == 0) begin
          in_gap = $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else begin
          nxt = pixel_q.pop_front();
          in_valid     <= 1'b1;
          in_pixel_col <= nxt.col;
          in_pixel_row <= nxt.row;
        end
      end
    end
  end

  // result monitor: checks each taken word against the oldest prediction,
  // and stalls the result channel in random bursts
  always @(posedge clk) begin : result_monitor
    logic [LIM_W-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (count_q.size() == 0) begin
          $display("%0t: escape_count expected no word, actual %0d",
                   $time, out_escape_count);
          errors++;
        end else begin
          want = count_q.pop_front();
          if (out_escape_count !== want) begin
            $display("%0t: escape_count expected %0d, actual %0d",
                     $time, want, out_escape_count);
            errors++;
          end
        end
      end
      // stall stays high until its burst runs out
      if (out_hold > 0) begin
        out_hold--;
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        out_hold = $urandom_range(1, 13) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // hang detection: too long with no word moving on any channel
  always @(posedge clk) begin : hang_watch
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/mec_pkg.sv
rtl/mandelbrot_escape_counter_unit.sv
tb/mandelbrot_escape_counter_unit_test.sv
